### rtl/bhf_pkg.sv
// Package for the buffer hash block: constants, the mix request struct and
// the per-byte update and final mix functions. No dependencies.
package bhf_pkg;

  localparam logic [31:0] FnvPrime  = 32'd16777619;
  localparam logic [31:0] FnvOffset = 32'd2166136261;

  // finished byte-stage hash handed to the mix stage
  typedef struct packed {
    logic [31:0] hash;
    logic        zero_only;
  } bhf_mix_req_t;

  // one fnv-1a byte step, modulo 2^32
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

  // arithmetic right shift, fill from bit 31
  function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // final avalanche: add, xor, add, xor, add
  function automatic logic [31:0] final_mix(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h + (h << 13);
    h = h ^ sra(h, 5'd7);
    h = h + (h << 3);
    h = h ^ sra(h, 5'd17);
    h = h + (h << 5);
    return h;
  endfunction

endpackage

### rtl/bhf_accum.sv
// Byte stage: running fnv-1a hash and all-zero flag, plus the register that
// holds a finished buffer hash for the mix stage. Depends on bhf_pkg.
module bhf_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 mix_take_i,
  output logic                 mix_valid_o,
  output bhf_pkg::bhf_mix_req_t mix_req_o
);
  import bhf_pkg::*;

  logic [31:0]  hash_q, hash_d;
  logic         zero_q, zero_d;
  logic         mix_valid_q, mix_valid_d;
  bhf_mix_req_t mix_req_q, mix_req_d;
  logic [31:0]  step_hash;
  logic         step_zero;

  // per-beat update of the running state
  always_comb begin
    step_hash   = fnv_step(hash_q, data_byte_i);
    step_zero   = zero_q & (data_byte_i == 8'd0);
    hash_d      = hash_q;
    zero_d      = zero_q;
    mix_valid_d = mix_valid_q & ~mix_take_i;
    mix_req_d   = mix_req_q;
    if (accept_i) begin
      if (last_byte_i) begin
        hash_d      = FnvOffset;
        zero_d      = 1'b1;
        mix_valid_d = 1'b1;
        mix_req_d   = '{hash: step_hash, zero_only: step_zero};
      end else begin
        hash_d = step_hash;
        zero_d = step_zero;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= FnvOffset;
      zero_q      <= 1'b1;
      mix_valid_q <= 1'b0;
    end else begin
      hash_q      <= hash_d;
      zero_q      <= zero_d;
      mix_valid_q <= mix_valid_d;
    end
  end

  // payload of the finished hash
  always_ff @(posedge clk_i) begin
    mix_req_q <= mix_req_d;
  end

  assign mix_valid_o = mix_valid_q;
  assign mix_req_o   = mix_req_q;

endmodule

### rtl/bhf_mix.sv
// Mix stage: applies the final avalanche to a finished buffer hash and holds
// the result in the output register. Depends on bhf_pkg.
module bhf_mix (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mix_valid_i,
  input  bhf_pkg::bhf_mix_req_t mix_req_i,
  output logic                  mix_take_o,
  input  logic                  stall_i,
  output logic                  valid_o,
  output logic [31:0]           hash_value_o
);
  import bhf_pkg::*;

  logic        valid_q;
  logic        load;
  logic [31:0] hash_q, hash_d;

  // output register is free when empty or being taken
  assign load       = ~valid_q | ~stall_i;
  assign mix_take_o = mix_valid_i & load;

  // final mix, forced to zero for an all-zero buffer
  always_comb begin
    hash_d = mix_req_i.zero_only ? 32'd0 : final_mix(mix_req_i.hash);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= mix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix_take_o) begin
      hash_q <= hash_d;
    end
  end

  assign valid_o      = valid_q;
  assign hash_value_o = hash_q;

endmodule

### rtl/buffer_hash_fnv1a_mixed_top.sv
// Buffer hash top level: byte stage and mix stage joined by a one-entry
// register. Depends on bhf_pkg, bhf_accum and bhf_mix.
//
// Usage:
//   Input channel (valid_i / stall_o) carries one byte per beat with
//   last_byte_i marking the final byte of a buffer. Output channel
//   (valid_o / stall_i) carries one 32-bit hash per buffer, 0 when every
//   byte of the buffer was zero.
//   Throughput: one byte per cycle while stall_o is low; the byte step is
//   one constant multiply in the byte stage register loop.
//   Path: the finished hash is written to the mix register at the edge that
//   takes the last byte and moves on into the output register once that
//   register is empty or being taken.
//   Reset: the running hash reloads the offset basis, the zero flag sets and
//   both pipeline registers empty. The running state reloads again after
//   every last byte.
//   Receiver stall: the output register holds its beat; a second finished
//   hash waits in the mix register, and only when both are full and the
//   receiver stalls is stall_o raised.
module buffer_hash_fnv1a_mixed_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] hash_value_o
);
  import bhf_pkg::*;

  logic         accept;
  logic         mix_valid;
  logic         mix_take;
  bhf_mix_req_t mix_req;

  // input beat taken unless the mix register is full and cannot drain
  assign stall_o = mix_valid & ~mix_take;
  assign accept  = valid_i & ~stall_o;

  bhf_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .mix_take_i  (mix_take),
    .mix_valid_o (mix_valid),
    .mix_req_o   (mix_req)
  );

  bhf_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mix_valid_i  (mix_valid),
    .mix_req_i    (mix_req),
    .mix_take_o   (mix_take),
    .stall_i      (stall_i),
    .valid_o      (valid_o),
    .hash_value_o (hash_value_o)
  );

endmodule

### rtl/bhf_checker.sv
// Port-level checks for the buffer hash top level, bound to it below.
// Depends only on the top level's ports.
module bhf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        last_byte_i,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] hash_value_o
);

  // a stalled output beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its hash
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(hash_value_o))
    else $error("output hash changed while stalled");

  // input side only stalls when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output back-pressure");

  // a taken last byte must be followed by a valid beat on the output
  a_last_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && last_byte_i |=> ##1 valid_o)
    else $error("no result after last byte");

  // no output straight after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o)
    else $error("output valid out of reset");

endmodule

bind buffer_hash_fnv1a_mixed_top bhf_checker u_bhf_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for buffer_hash_fnv1a_mixed_top: drives byte buffers
// with random gaps and stalls and predicts each mixed hash independently.
// Depends on bhf_pkg and the buffer hash RTL.
module tb_top;
  import bhf_pkg::*;

  typedef struct {
    logic [7:0]  byte_val;
    logic        last;
    bit          known;
    logic [31:0] hash;
  } stim_row_t;

  localparam int NumRows = 21;
  localparam int TargetBytes = 2000;
  localparam int LongHold = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        valid_o;
  logic        stall_i;
  logic [31:0] hash_value_o;

  // predictor state
  logic [31:0] hash_state;
  bit          zero_run;
  logic [31:0] expected_hashes[$];
  int          err_cnt;
  int          bytes_sent;
  bit          long_hold_req;
  bit          burst_mode;

  // directed buffers: zero-only buffers read off directly, the rest predicted
  stim_row_t stim_rows [NumRows] = '{
    '{8'h00, 1'b1, 1'b1, 32'd0},
    '{8'h00, 1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b1, 1'b1, 32'd0},
    '{8'hFF, 1'b1, 1'b0, 32'd0},
    '{8'h01, 1'b1, 1'b0, 32'd0},
    '{8'h80, 1'b1, 1'b0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 32'd0},
    '{8'h01, 1'b1, 1'b0, 32'd0},
    '{8'h01, 1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b1, 1'b0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 32'd0},
    '{8'hFF, 1'b1, 1'b0, 32'd0},
    '{8'hAA, 1'b0, 1'b0, 32'd0},
    '{8'h55, 1'b1, 1'b0, 32'd0},
    '{8'h7F, 1'b1, 1'b0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 32'd0},
    '{8'h80, 1'b1, 1'b0, 32'd0}
  };

  buffer_hash_fnv1a_mixed_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .hash_value_o (hash_value_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // avalanche applied at the end of a buffer, shifts right fill from bit 31
  function automatic logic [31:0] avalanche_mix(input logic [31:0] v);
    logic [31:0] m;
    m = v;
    m = m + (m << 13);
    m = m ^ $unsigned($signed(m) >>> 7);
    m = m + (m << 3);
    m = m ^ $unsigned($signed(m) >>> 17);
    m = m + (m << 5);
    return m;
  endfunction

  // absorb one byte; returns 1 with the finished hash at the end of a buffer
  function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                     output logic [31:0] hash);
    if (b != 8'd0) zero_run = 1'b0;
    hash_state = (hash_state ^ {24'd0, b}) * FnvPrime;
    hash = 32'd0;
    if (!last) return 1'b0;
    hash = zero_run ? 32'd0 : avalanche_mix(hash_state);
    hash_state = FnvOffset;
    zero_run = 1'b1;
    return 1'b1;
  endfunction

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 16);
  endfunction

  // offer one beat after a gap and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic last, input int gap,
                           input bit known, input logic [31:0] typed_hash);
    logic [31:0] predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    valid_i     <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (stall_o);
    bytes_sent++;
    if (absorb_byte(b, last, predicted))
      expected_hashes.push_back(known ? typed_hash : predicted);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
  endtask

  // one buffer of random length and flavour
  task automatic send_buffer(input int len);
    int          kind;
    logic [7:0]  b;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == len - 1, draw_gap(), 1'b0, 32'd0);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    logic [31:0] exp_hash;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_hashes.size() == 0) begin
        $error("hash_value: unexpected beat, actual %08h", hash_value_o);
        err_cnt++;
      end else begin
        exp_hash = expected_hashes.pop_front();
        if (hash_value_o !== exp_hash) begin
          $error("hash_value: expected %08h, actual %08h", exp_hash, hash_value_o);
          err_cnt++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int busy;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        busy = LongHold;
        long_hold_req = 1'b0;
      end else begin
        busy = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      @(negedge clk_i);
      if (busy > 0) begin
        stall_i <= 1'b1;
        repeat (busy) @(negedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // stimulus
  initial begin
    int len;
    bit held, paused;
    valid_i       = 1'b0;
    data_byte_i   = 8'd0;
    last_byte_i   = 1'b0;
    rst_ni        = 1'b0;
    err_cnt       = 0;
    bytes_sent    = 0;
    long_hold_req = 1'b0;
    burst_mode    = 1'b0;
    hash_state    = FnvOffset;
    zero_run      = 1'b1;
    held          = 1'b0;
    paused        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (stim_rows[i])
      send_byte(stim_rows[i].byte_val, stim_rows[i].last, draw_gap(),
                stim_rows[i].known, stim_rows[i].hash);

    // random buffers
    while (bytes_sent < TargetBytes) begin
      if (!held && bytes_sent > 600) begin
        // receiver holds off while short buffers keep coming back to back
        held = 1'b1;
        long_hold_req = 1'b1;
        burst_mode = 1'b1;
        for (int n = 0; n < 15; n++) send_buffer($urandom_range(1, 3));
      end
      if (!paused && bytes_sent > 1200) begin
        paused = 1'b1;
        wait_drained();
      end
      burst_mode = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      send_buffer(len);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0)
      $display("buffer_hash_fnv1a_mixed_top verification clean");
    else
      $display("buffer_hash_fnv1a_mixed_top verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("buffer_hash_fnv1a_mixed_top verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/bhf_pkg.sv
rtl/bhf_accum.sv
rtl/bhf_mix.sv
rtl/buffer_hash_fnv1a_mixed_top.sv
rtl/bhf_checker.sv
sim/tb_top.sv
